/* rtl/lir_pkg.sv */
package lir_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 24;
  localparam int ACTION_W   = 2;
  localparam int IN_LEN_W   = 14;
  localparam int OUT_LEN_W  = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  // Parameter defaults
  localparam int MAX_INPUT_SAMPLES_DEF = 8192;
  localparam int FRACTION_BITS_DEF     = 8;

  // Register reset values
  localparam logic [IN_LEN_W-1:0]  IN_LEN_RST  = IN_LEN_W'(8192);
  localparam logic [OUT_LEN_W-1:0] OUT_LEN_RST = OUT_LEN_W'(8192);

  // Action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_EMIT    = 2'd1,
    ACT_RESTART = 2'd2
  } action_t;

  // Config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_LENGTH  = 1'b0,
    CFG_OUT_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last;
  } out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_POS,
    ST_DIV_LOAD,
    ST_DIV,
    ST_RD_K,
    ST_RD_K1,
    ST_MAC,
    ST_FIN
  } state_t;

  // Operand select for the shared multiplier
  typedef enum logic [1:0] {
    MUL_POS,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     kf_en;
    logic     rd_k1;
    logic     acc_en;
    logic     out_load;
  } ctrl_t;

endpackage

/* rtl/lir_store.sv */
module lir_store import lir_pkg::*; #(
  parameter int DEPTH = MAX_INPUT_SAMPLES_DEF,
  parameter int WIDTH = SAMPLE_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lir_div.sv */
module lir_div import lir_pkg::*; #(
  parameter int NUM_W = 46,
  parameter int DEN_W = OUT_LEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             last,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in a numerator bit, try to subtract
  always_comb begin
    rem_sh  = {rem_r, nq_r[NUM_W-1]};
    diff    = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    nq_nxt  = {nq_r[NUM_W-2:0], ge};
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Remainder and shared numerator/quotient shifter
  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      nq_r  <= nq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign last = (cnt_r == CNT_W'(1));
  assign quot = nq_r;

endmodule

/* rtl/lir_seq.sv */
module lir_seq import lir_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  emit_go,
  input  logic  div_last,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (emit_go) state_nxt = ST_MUL_POS;
      ST_MUL_POS:  state_nxt = ST_DIV_LOAD;
      ST_DIV_LOAD: state_nxt = ST_DIV;
      ST_DIV:      if (div_last) state_nxt = ST_RD_K;
      ST_RD_K:     state_nxt = ST_RD_K1;
      ST_RD_K1:    state_nxt = ST_MAC;
      ST_MAC:      state_nxt = ST_FIN;
      ST_FIN:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MUL_POS;
    unique case (state_r)
      ST_IDLE:     ctrl.in_ready = 1'b1;
      ST_MUL_POS: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_POS;
      end
      ST_DIV_LOAD: ctrl.div_start = 1'b1;
      ST_DIV:      ;
      ST_RD_K:     ctrl.kf_en = 1'b1;
      ST_RD_K1: begin
        ctrl.rd_k1   = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_LO;
      end
      ST_MAC: begin
        ctrl.acc_en  = 1'b1;
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MUL_HI;
      end
      ST_FIN:      ctrl.out_load = out_free;
      default:     ;
    endcase
  end

endmodule

/* rtl/linear_interp_resampler.sv */
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_valid/in_ready   | in_t: action, sample_in
// out_    | out | out_valid/out_ready | out_t: sample_out, last
// cfg_    | in  | cfg_we              | cfg_index, cfg_data (no read-back)
//
// An emit finds its position with the restoring divider, which produces one
// quotient bit of the position per cycle.
// Reset (rst_n, synchronous) clears pointers and the sequencer and sets both
// lengths to 8192; the sample store is not cleared. A stalled result waits in
// the output register while loads and restarts go on; the next emit holds in
// its last step.
module linear_interp_resampler import lir_pkg::*; #(
  parameter int MAX_INPUT_SAMPLES = MAX_INPUT_SAMPLES_DEF,
  parameter int FRACTION_BITS     = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_payload,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW     = $clog2(MAX_INPUT_SAMPLES);
  localparam int LEN_W  = $clog2(MAX_INPUT_SAMPLES + 1);
  localparam int FB1    = FRACTION_BITS + 1;
  localparam int MA_W   = (SAMPLE_W > OUT_LEN_W) ? SAMPLE_W : OUT_LEN_W;
  localparam int MB_W   = (LEN_W > FB1) ? LEN_W : FB1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int PP_W   = OUT_LEN_W + LEN_W;
  localparam int NUM_W  = PP_W + FRACTION_BITS;
  localparam int POS_W  = LEN_W + FRACTION_BITS;
  localparam int ACC_W  = SAMPLE_W + FRACTION_BITS;
  localparam logic [FRACTION_BITS:0] SCALE = FB1'(1) << FRACTION_BITS;
  localparam logic [LEN_W-1:0]       MAX_LEN = LEN_W'(MAX_INPUT_SAMPLES);

  ctrl_t ctrl;

  logic [IN_LEN_W-1:0]  in_len_r;
  logic [OUT_LEN_W-1:0] out_len_r;
  logic [LEN_W-1:0]     wp_r;
  logic [OUT_LEN_W-1:0] out_idx_r;

  logic [OUT_LEN_W-1:0] idx_r;
  logic [LEN_W-1:0]     len_r;
  logic [OUT_LEN_W-1:0] olen_r;
  logic                 last_r;

  logic [LEN_W-1:0]     len_eff;
  logic [OUT_LEN_W-1:0] olen_eff;
  logic [OUT_LEN_W-1:0] idx_eff;
  logic                 is_last;

  logic in_fire, load_go, emit_go, restart_go, store_we;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_sum;

  logic             div_last;
  logic [NUM_W-1:0] quot;

  logic [POS_W-1:0]         pos;
  logic [LEN_W-1:0]         k_raw, k, len_m1;
  logic [LEN_W:0]           k_inc;
  logic [LEN_W-1:0]         k1;
  logic [AW-1:0]            k1_r;
  logic [FRACTION_BITS-1:0] frac_r;
  logic [AW-1:0]            raddr;
  logic [SAMPLE_W-1:0]      rdata;
  logic [SAMPLE_W-1:0]      biased;

  logic out_valid_r;
  out_t out_payload_r;
  logic out_free;

  // Handshake decode
  assign in_ready   = ctrl.in_ready;
  assign in_fire    = in_valid && in_ready;
  assign load_go    = in_fire && (in_data.action == ACT_LOAD);
  assign emit_go    = in_fire && (in_data.action == ACT_EMIT);
  assign restart_go = in_fire && (in_data.action == ACT_RESTART);
  assign store_we   = load_go && (wp_r < MAX_LEN);
  assign out_free   = !out_valid_r || out_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_len_r  <= IN_LEN_RST;
      out_len_r <= OUT_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_IN_LENGTH:  in_len_r  <= cfg_data[IN_LEN_W-1:0];
        CFG_OUT_LENGTH: out_len_r <= cfg_data[OUT_LEN_W-1:0];
        default:        ;
      endcase
    end
  end

  // Effective lengths and current output index
  always_comb begin
    if (in_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(in_len_r) > 32'(MAX_INPUT_SAMPLES)) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = LEN_W'(in_len_r);
    end
    olen_eff = (out_len_r == '0) ? OUT_LEN_W'(1) : out_len_r;
    idx_eff  = (out_idx_r >= olen_eff) ? '0 : out_idx_r;
    is_last  = (idx_eff == olen_eff - OUT_LEN_W'(1));
  end

  // Write pointer and output index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      out_idx_r <= '0;
    end else if (restart_go) begin
      wp_r      <= '0;
      out_idx_r <= '0;
    end else begin
      if (store_we) begin
        wp_r <= wp_r + LEN_W'(1);
      end
      if (emit_go) begin
        out_idx_r <= is_last ? '0 : idx_eff + OUT_LEN_W'(1);
      end
    end
  end

  // Per-emit operands
  always_ff @(posedge clk) begin
    if (emit_go) begin
      idx_r  <= idx_eff;
      len_r  <= len_eff;
      olen_r <= olen_eff;
      last_r <= is_last;
    end
  end

  // Shared multiplier operand select
  assign biased = {~rdata[SAMPLE_W-1], rdata[SAMPLE_W-2:0]};

  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_POS: begin
        mul_a = MA_W'(idx_r);
        mul_b = MB_W'(len_r);
      end
      MUL_LO: begin
        mul_a = MA_W'(biased);
        mul_b = MB_W'(SCALE - {1'b0, frac_r});
      end
      MUL_HI: begin
        mul_a = MA_W'(biased);
        mul_b = MB_W'(frac_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // Position divider
  lir_div #(
    .NUM_W (NUM_W),
    .DEN_W (OUT_LEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.div_start),
    .num   ({prod_r[PP_W-1:0], {FRACTION_BITS{1'b0}}}),
    .den   (olen_r),
    .last  (div_last),
    .quot  (quot)
  );

  // Entry selection, clamped at the last used entry
  always_comb begin
    pos    = quot[POS_W-1:0];
    k_raw  = pos[POS_W-1:FRACTION_BITS];
    len_m1 = len_r - LEN_W'(1);
    k      = (k_raw > len_m1) ? len_m1 : k_raw;
    k_inc  = {1'b0, k} + (LEN_W + 1)'(1);
    k1     = (k_inc < {1'b0, len_r}) ? k_inc[LEN_W-1:0] : len_m1;
    raddr  = ctrl.rd_k1 ? k1_r : k[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.kf_en) begin
      k1_r   <= k1[AW-1:0];
      frac_r <= pos[FRACTION_BITS-1:0];
    end
  end

  // Sample store
  lir_store #(
    .DEPTH (MAX_INPUT_SAMPLES),
    .WIDTH (SAMPLE_W)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp_r[AW-1:0]),
    .wdata (in_data.sample_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Blend accumulator
  always_ff @(posedge clk) begin
    if (ctrl.acc_en) begin
      acc_r <= prod_r[ACC_W-1:0];
    end
  end

  assign acc_sum = acc_r + prod_r[ACC_W-1:0];

  // Sequencer
  lir_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .emit_go  (emit_go),
    .div_last (div_last),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_payload_r.sample_out <= {~acc_sum[ACC_W-1], acc_sum[ACC_W-2:FRACTION_BITS]};
      out_payload_r.last       <= last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule
